// File: src/vmix_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vmix_pkg
// Shared constants and types for the voice mixer.
// ----------------------------------------------------------------------------
package vmix_pkg;

  localparam int unsigned VOICE_COUNT  = 16;
  localparam int unsigned SAMPLE_DEPTH = 65536;

  localparam int unsigned VIDX_W  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int unsigned SADDR_W = $clog2(SAMPLE_DEPTH);

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned POS_W    = 17;
  localparam int unsigned BASE_W   = 16;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'h8000;

  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_MIX   = 2'd2;

  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef struct packed {
    logic              looping;
    logic [GAIN_W-1:0] gain_right;
    logic [GAIN_W-1:0] gain_left;
    logic [POS_W-1:0]  length;
    logic [BASE_W-1:0] base;
    logic [POS_W-1:0]  position;
  } voice_t;

  typedef struct packed {
    logic clr;
    logic mul1;
    logic mul2;
    logic acc;
  } mac_ctrl_t;

  function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
    return (g > UNITY_GAIN) ? UNITY_GAIN : g;
  endfunction

endpackage
`default_nettype wire

// File: src/vmix_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vmix_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module vmix_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: src/vmix_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vmix_mac
// One channel: sample times gain times master, scaled, saturating sum.
// ----------------------------------------------------------------------------
module vmix_mac import vmix_pkg::*; (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  mac_ctrl_t                  ctrl_i,
  input  wire signed [SAMPLE_W-1:0]  sample_i,
  input  wire [GAIN_W-1:0]           gain_i,
  input  wire [GAIN_W-1:0]           master_i,
  output logic signed [SAMPLE_W-1:0] acc_o
);

  logic signed [32:0] p1_q;
  logic signed [49:0] p2_q;
  logic signed [49:0] biased;
  logic signed [17:0] scaled;
  logic signed [18:0] sum;
  logic signed [SAMPLE_W-1:0] acc_q;

  always_comb begin
    biased = p2_q + (p2_q[49] ? 50'sd1073741823 : 50'sd0);
    scaled = 18'(biased >>> 30);
    sum    = 19'(acc_q) + 19'(scaled);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul1) begin
      p1_q <= 33'(sample_i) * $signed({17'd0, gain_i});
    end
    if (ctrl_i.mul2) begin
      p2_q <= 50'(p1_q) * $signed({34'd0, master_i});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc) begin
      if (sum > 19'sd32767) begin
        acc_q <= 16'sh7fff;
      end else if (sum < -19'sd32768) begin
        acc_q <= 16'sh8000;
      end else begin
        acc_q <= 16'(sum);
      end
    end
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

// File: src/voice_mixer_with_stealing.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voice_mixer_with_stealing
// Stereo voice mixer: voice table and sample store in RAM, voice stealing.
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tuser: action; tdata: address, value, base, length, gains, loop
// m_axis    out  tuser: kind; tdata: started, voice_slot, left, right
// cfg       in   master_volume
// Load: writes the sample RAM and stays idle. Start: a zero length goes
// straight to done, a free voice is written at once, and when stealing the
// gain-sum scan first reads and compares each voice RAM entry in turn.
// Mix: each playing voice passes through the voice RAM, the sample RAM and the
// two multiplier stages; an idle voice is only read and decoded;
// a zero master goes straight to done.
// A word waiting on m_axis stalls only the completion of the next item.
// Reset clears active flags and sets master to unity; RAMs need no clearing.
// ----------------------------------------------------------------------------
module voice_mixer_with_stealing import vmix_pkg::*; (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  // action[1:0]
  input  wire [1:0]             s_axis_tuser,
  // sample_address[15:0], sample_value[31:16], clip_base[47:32],
  // clip_length[64:48], gain_left[80:65], gain_right[96:81], loop_flag[97]
  input  wire [IN_DATA_W-1:0]   s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  // kind[0]
  output logic                  m_axis_tuser,
  // started[0], voice_slot[4:1], left[20:5], right[36:21]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  wire                   cfg_we_i,
  input  wire [GAIN_W-1:0]      cfg_wdata_i
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SRD  = 4'd1;
  localparam logic [3:0] ST_SCMP = 4'd2;
  localparam logic [3:0] ST_SWR  = 4'd3;
  localparam logic [3:0] ST_MRD  = 4'd4;
  localparam logic [3:0] ST_MDEC = 4'd5;
  localparam logic [3:0] ST_MUL1 = 4'd6;
  localparam logic [3:0] ST_MUL2 = 4'd7;
  localparam logic [3:0] ST_MACC = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  localparam logic [VIDX_W-1:0] LAST_IDX = VIDX_W'(VOICE_COUNT - 1);

  logic [3:0] state_q, state_d;
  logic [VIDX_W-1:0] idx_q, idx_d, slot_q, slot_d;
  logic [VOICE_COUNT-1:0] active_q, active_d;
  logic [GAIN_W-1:0] master_q;
  logic [17:0] best_q, best_d;
  logic kind_q, kind_d, started_q, started_d;
  voice_t req_q, req_d;
  logic [GAIN_W-1:0] gl_q, gl_d, gr_q, gr_d;

  logic m_valid_q;
  logic m_kind_q;
  logic [OUT_DATA_W-1:0] m_data_q;

  logic in_acc, out_load;
  logic any_free;
  logic [VIDX_W-1:0] free_idx;

  logic vr_we;
  logic [VIDX_W-1:0] vr_waddr, vr_raddr;
  voice_t vr_wdata, vr_rdata;
  logic sr_we;
  logic [SADDR_W-1:0] sr_waddr, sr_raddr;
  logic [SAMPLE_W-1:0] sr_rdata;

  mac_ctrl_t mac_ctrl;
  logic signed [SAMPLE_W-1:0] acc_l, acc_r;

  logic [POS_W-1:0] pos_eff;
  logic [17:0] gsum;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        any_free = 1'b1;
        free_idx = VIDX_W'(i);
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    slot_d    = slot_q;
    active_d  = active_q;
    best_d    = best_q;
    kind_d    = kind_q;
    started_d = started_q;
    req_d     = req_q;
    gl_d      = gl_q;
    gr_d      = gr_q;
    vr_we     = 1'b0;
    vr_waddr  = idx_q;
    vr_wdata  = vr_rdata;
    vr_raddr  = idx_q;
    sr_we     = 1'b0;
    sr_waddr  = SADDR_W'(s_axis_tdata[15:0]);
    sr_raddr  = '0;
    mac_ctrl  = '0;
    pos_eff   = vr_rdata.position;
    gsum      = 18'(vr_rdata.gain_left) + 18'(vr_rdata.gain_right);

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mac_ctrl.clr = 1'b1;
          case (s_axis_tuser)
            ACT_LOAD: begin
              sr_we = 1'b1;
            end
            ACT_START: begin
              req_d.position   = '0;
              req_d.base       = s_axis_tdata[47:32];
              req_d.length     = s_axis_tdata[64:48];
              req_d.gain_left  = clamp_gain(s_axis_tdata[80:65]);
              req_d.gain_right = clamp_gain(s_axis_tdata[96:81]);
              req_d.looping    = s_axis_tdata[97];
              kind_d = KIND_ACK;
              slot_d = '0;
              idx_d  = '0;
              if (s_axis_tdata[64:48] == '0) begin
                started_d = 1'b0;
                state_d   = ST_DONE;
              end else if (any_free) begin
                started_d = 1'b1;
                slot_d    = free_idx;
                state_d   = ST_SWR;
              end else begin
                started_d = 1'b1;
                state_d   = ST_SRD;
              end
            end
            ACT_MIX: begin
              kind_d    = KIND_FRAME;
              started_d = 1'b0;
              slot_d    = '0;
              idx_d     = '0;
              state_d   = (master_q == '0) ? ST_DONE : ST_MRD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SRD: begin
        state_d = ST_SCMP;
      end
      ST_SCMP: begin
        if (idx_q == '0 || gsum < best_q) begin
          best_d = gsum;
          slot_d = idx_q;
        end
        if (idx_q == LAST_IDX) begin
          state_d = ST_SWR;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_SRD;
        end
      end
      ST_SWR: begin
        vr_we            = 1'b1;
        vr_waddr         = slot_q;
        vr_wdata         = req_q;
        active_d[slot_q] = 1'b1;
        state_d          = ST_DONE;
      end
      ST_MRD: begin
        state_d = ST_MDEC;
      end
      ST_MDEC: begin
        gl_d = vr_rdata.gain_left;
        gr_d = vr_rdata.gain_right;
        if (!active_q[idx_q]) begin
          state_d = (idx_q == LAST_IDX) ? ST_DONE : ST_MRD;
          idx_d   = (idx_q == LAST_IDX) ? idx_q : idx_q + 1'b1;
        end else if (vr_rdata.position >= vr_rdata.length && !vr_rdata.looping) begin
          active_d[idx_q] = 1'b0;
          state_d = (idx_q == LAST_IDX) ? ST_DONE : ST_MRD;
          idx_d   = (idx_q == LAST_IDX) ? idx_q : idx_q + 1'b1;
        end else begin
          if (vr_rdata.position >= vr_rdata.length) begin
            pos_eff = '0;
          end
          sr_raddr          = SADDR_W'(18'(vr_rdata.base) + 18'(pos_eff));
          vr_we             = 1'b1;
          vr_wdata.position = pos_eff + 1'b1;
          state_d           = ST_MUL1;
        end
      end
      ST_MUL1: begin
        mac_ctrl.mul1 = 1'b1;
        state_d       = ST_MUL2;
      end
      ST_MUL2: begin
        mac_ctrl.mul2 = 1'b1;
        state_d       = ST_MACC;
      end
      ST_MACC: begin
        mac_ctrl.acc = 1'b1;
        state_d = (idx_q == LAST_IDX) ? ST_DONE : ST_MRD;
        idx_d   = (idx_q == LAST_IDX) ? idx_q : idx_q + 1'b1;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      active_q  <= '0;
      master_q  <= UNITY_GAIN;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      active_q <= active_d;
      if (cfg_we_i) begin
        master_q <= clamp_gain(cfg_wdata_i);
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    slot_q    <= slot_d;
    best_q    <= best_d;
    kind_q    <= kind_d;
    started_q <= started_d;
    req_q     <= req_d;
    gl_q      <= gl_d;
    gr_q      <= gr_d;
    if (out_load) begin
      m_kind_q <= kind_q;
      m_data_q <= {3'd0,
                   (kind_q == KIND_FRAME) ? acc_r : 16'sd0,
                   (kind_q == KIND_FRAME) ? acc_l : 16'sd0,
                   4'(slot_q), started_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tdata  = m_data_q;

  vmix_ram #(.WIDTH($bits(voice_t)), .DEPTH(1 << VIDX_W)) u_voice_ram (
    .clk_i  (clk_i),
    .we_i   (vr_we),
    .waddr_i(vr_waddr),
    .wdata_i(vr_wdata),
    .raddr_i(vr_raddr),
    .rdata_o(vr_rdata)
  );

  vmix_ram #(.WIDTH(SAMPLE_W), .DEPTH(SAMPLE_DEPTH)) u_sample_ram (
    .clk_i  (clk_i),
    .we_i   (sr_we),
    .waddr_i(sr_waddr),
    .wdata_i(s_axis_tdata[31:16]),
    .raddr_i(sr_raddr),
    .rdata_o(sr_rdata)
  );

  vmix_mac u_mac_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .sample_i(sr_rdata),
    .gain_i  (gl_q),
    .master_i(master_q),
    .acc_o   (acc_l)
  );

  vmix_mac u_mac_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .sample_i(sr_rdata),
    .gain_i  (gr_q),
    .master_i(master_q),
    .acc_o   (acc_r)
  );

  a_master_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    master_q <= UNITY_GAIN) else $error("master above unity");

  a_claim_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SWR |=> active_q[$past(slot_q)]) else $error("claimed voice not active");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !s_axis_tready) else $error("accept while busy");

  a_mix_master: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MRD |-> master_q != '0) else $error("mix with silent master");

endmodule
`default_nettype wire
